FILE: rtl/ssc_pkg.sv
// Types, codes and segment table shared by the seven-segment scan controller.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned SegW    = 8;
  localparam int unsigned NumW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned QuotW   = 29;

  localparam logic [OpW-1:0] OpScan  = 3'd0;
  localparam logic [OpW-1:0] OpSet   = 3'd1;
  localparam logic [OpW-1:0] OpClear = 3'd2;
  localparam logic [OpW-1:0] OpTest  = 3'd3;
  localparam logic [OpW-1:0] OpShow  = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgBlank = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTest  = 2'd1;

  localparam logic [SegW-1:0] BlankReset = 8'hFF;
  localparam logic [SegW-1:0] TestReset  = 8'h00;
  localparam logic [SegW-1:0] AllOff     = 8'hFF;
  localparam logic [SegW-1:0] NoSegments = 8'h00;

  // ceil(2^35 / 10); quotient is (n * Recip10) >> 35 for any 32-bit n
  localparam logic [NumW-1:0] Recip10   = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] position;
    logic [SegW-1:0] digit_value;
    logic [NumW-1:0] number;
  } in_t;

  typedef struct packed {
    logic            serial_bit;
    logic [SegW-1:0] segments;
    logic [SegW-1:0] digit_select;
    logic            last;
  } out_t;

  typedef struct packed {
    logic scan_start;
    logic set_digit;
    logic fill_blank;
    logic fill_test;
    logic num_start;
    logic mul;
    logic digit;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic bit_last;
    logic num_done;
  } status_t;

  function automatic logic [SegW-1:0] hex_seg(input logic [3:0] v);
    logic [SegW-1:0] s;
    unique case (v)
      4'h0: s = 8'hC0;
      4'h1: s = 8'hF9;
      4'h2: s = 8'hA4;
      4'h3: s = 8'hB0;
      4'h4: s = 8'h99;
      4'h5: s = 8'h92;
      4'h6: s = 8'h82;
      4'h7: s = 8'hF8;
      4'h8: s = 8'h80;
      4'h9: s = 8'h90;
      4'hA: s = 8'h88;
      4'hB: s = 8'h83;
      4'hC: s = 8'hC6;
      4'hD: s = 8'hA1;
      4'hE: s = 8'h86;
      4'hF: s = 8'h8E;
      default: s = 8'hC0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/ssc_ctrl.sv
// Sequencing state machine for the seven-segment scan controller.
`timescale 1ns / 1ps

module ssc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [ssc_pkg::OpW-1:0] op_i,
  output logic                    in_stall_o,
  input  ssc_pkg::status_t        status_i,
  output ssc_pkg::cmd_t           cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StMul  = 4'b0100,
    StDig  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (op_i)
            ssc_pkg::OpScan: begin
              cmd_o.scan_start = 1'b1;
              state_d          = StScan;
            end
            ssc_pkg::OpSet:   cmd_o.set_digit  = 1'b1;
            ssc_pkg::OpClear: cmd_o.fill_blank = 1'b1;
            ssc_pkg::OpTest:  cmd_o.fill_test  = 1'b1;
            ssc_pkg::OpShow: begin
              cmd_o.num_start = 1'b1;
              state_d         = StMul;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (status_i.out_free) begin
          cmd_o.shift = 1'b1;
          if (status_i.bit_last) begin
            state_d = StIdle;
          end
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDig;
      end
      StDig: begin
        cmd_o.digit = 1'b1;
        state_d     = status_i.num_done ? StIdle : StMul;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ssc_dp.sv
// Pattern buffer, scan shifter, decimal conversion and output register.
`timescale 1ns / 1ps

module ssc_dp #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssc_pkg::in_t                in_i,
  input  logic                        cfg_we_i,
  input  logic [ssc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssc_pkg::SegW-1:0]    cfg_data_i,
  input  ssc_pkg::cmd_t               cmd_i,
  output ssc_pkg::status_t            status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ssc_pkg::out_t               out_o
);

  localparam int unsigned IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGITS - 1);

  logic [ssc_pkg::SegW-1:0]    store_q [DIGITS];
  logic [ssc_pkg::SegW-1:0]    blank_q, test_q, pat_q;
  logic [IdxW-1:0]             scan_q, k_q, wr_idx;
  logic [ssc_pkg::BitIdxW-1:0] bit_q;
  logic [ssc_pkg::NumW-1:0]    num_q;
  logic [ssc_pkg::QuotW-1:0]   quot_q;
  logic [2*ssc_pkg::NumW-1:0]  prod;
  logic [3:0]                  rem;
  logic [ssc_pkg::SegW-1:0]    set_val;
  logic                        set_ok, bit_last;
  logic                        out_valid_q;
  ssc_pkg::out_t               out_q;

  assign prod     = num_q * ssc_pkg::Recip10;
  assign rem      = num_q[3:0] - ({quot_q[0], 3'b000} + {quot_q[2:0], 1'b0});
  assign wr_idx   = LastIdx - k_q;
  assign set_ok   = (32'(in_i.position) < DIGITS);
  assign set_val  = (in_i.digit_value < 8'd16) ? ssc_pkg::hex_seg(in_i.digit_value[3:0])
                                               : in_i.digit_value;
  assign bit_last = (bit_q == {ssc_pkg::BitIdxW{1'b1}});

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.bit_last = bit_last;
  assign status_o.num_done = (k_q == LastIdx) || (quot_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= ssc_pkg::BlankReset;
      test_q  <= ssc_pkg::TestReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ssc_pkg::CfgBlank) begin
        blank_q <= cfg_data_i;
      end
      if (cfg_index_i == ssc_pkg::CfgTest) begin
        test_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        store_q[i] <= ssc_pkg::BlankReset;
      end
    end else begin
      if (cmd_i.fill_blank || cmd_i.num_start) begin
        for (int i = 0; i < DIGITS; i++) begin
          store_q[i] <= blank_q;
        end
      end else if (cmd_i.fill_test) begin
        for (int i = 0; i < DIGITS; i++) begin
          store_q[i] <= test_q;
        end
      end else if (cmd_i.set_digit && set_ok) begin
        store_q[in_i.position[IdxW-1:0]] <= set_val;
      end else if (cmd_i.digit) begin
        store_q[wr_idx] <= ssc_pkg::hex_seg(rem);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.shift && bit_last) begin
      scan_q <= (scan_q == LastIdx) ? '0 : scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      pat_q <= store_q[scan_q];
      bit_q <= '0;
    end else if (cmd_i.shift) begin
      bit_q <= bit_q + 1'b1;
    end
    if (cmd_i.num_start) begin
      num_q <= in_i.number;
      k_q   <= '0;
    end else if (cmd_i.digit) begin
      num_q <= ssc_pkg::NumW'(quot_q);
      k_q   <= k_q + 1'b1;
    end
    if (cmd_i.mul) begin
      quot_q <= prod[ssc_pkg::RecipShift +: ssc_pkg::QuotW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.shift) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      out_q.serial_bit   <= pat_q[~bit_q];
      out_q.segments     <= bit_last ? pat_q : ssc_pkg::NoSegments;
      out_q.digit_select <= bit_last ? ~(ssc_pkg::SegW'(1) << scan_q) : ssc_pkg::AllOff;
      out_q.last         <= bit_last;
    end
  end

endmodule

FILE: rtl/seven_segment_scan_controller.sv
// Top level of the eight-digit multiplexed seven-segment scan controller.
//
// Input channel (in_valid_i / in_stall_o / in_i) carries one command per
// transaction: scan tick, set digit, clear, self test or show number.
// Output channel (out_valid_o / out_stall_i / out_o) carries the serial
// shift data; a scan tick yields eight transactions, MSB first, the last
// one flagged with last and carrying the latched segments and the
// active-low digit select. Configuration writes (cfg_valid_i/cfg_ready_o)
// set the blank and self-test patterns; cfg_ready_o is always high.
// Set digit, clear and self test do not raise in_stall_o. A scan tick first
// reads the buffer into the pattern register, then shifts its bits out one
// at a time through the single output register. Show number blanks the buffer,
// then for each decimal digit runs the 32x32 reciprocal multiplier and then
// forms the remainder and writes the buffer.
// in_stall_o is high while a command is in progress. A stalled output
// holds its payload and the shifter waits. Reset blanks the buffer to
// 0xFF, zeroes the scan index and restores the default patterns.
`timescale 1ns / 1ps

module seven_segment_scan_controller #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ssc_pkg::in_t                in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ssc_pkg::out_t               out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ssc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssc_pkg::SegW-1:0]    cfg_data_i
);

  ssc_pkg::cmd_t    cmd;
  ssc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssc_dp #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_shift_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> status.out_free)
    else $error("shift into an occupied output register");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_last_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> $countones(~out_o.digit_select) == 1)
    else $error("digit select not one-hot on last bit");

  a_shift_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |->
      out_o.digit_select == ssc_pkg::AllOff && out_o.segments == ssc_pkg::NoSegments)
    else $error("digits driven while shifting");

endmodule

FILE: verif/tb_top.sv
// Testbench for the seven-segment scan controller: random commands, stalls and pattern writes.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [ssc_pkg::OpW-1:0]     OpRsv5  = 3'd5;
  localparam logic [ssc_pkg::OpW-1:0]     OpRsv6  = 3'd6;
  localparam logic [ssc_pkg::OpW-1:0]     OpRsv7  = 3'd7;
  localparam logic [ssc_pkg::CfgIdxW-1:0] CfgRsv2 = 2'd2;
  localparam logic [ssc_pkg::CfgIdxW-1:0] CfgRsv3 = 2'd3;

  localparam int unsigned Digits       = 8;
  localparam int unsigned IdlePause    = 24;
  localparam int unsigned RandPerPhase = 60;
  localparam int unsigned NumPhases    = 5;
  localparam int unsigned TimeoutNs    = 4_000_000;

  // hex glyphs, digit 0 in the low byte
  localparam logic [16*ssc_pkg::SegW-1:0] HexGlyphs = {
    8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  ssc_pkg::in_t                  in_i        = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  ssc_pkg::out_t                 out_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [ssc_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ssc_pkg::SegW-1:0]      cfg_data_i  = '0;

  seven_segment_scan_controller #(
    .DIGITS(Digits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // predicted display state
  logic [ssc_pkg::SegW-1:0] seg_buf [Digits];
  int unsigned              scan_pos = 0;
  logic [ssc_pkg::SegW-1:0] blank_pat = ssc_pkg::BlankReset;
  logic [ssc_pkg::SegW-1:0] test_pat  = ssc_pkg::TestReset;

  ssc_pkg::in_t  cmd_q [$];
  ssc_pkg::out_t shift_exp_q [$];

  bit          in_pace   = 1'b1;
  bit          out_pace  = 1'b1;
  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_hold  = 0;

  int unsigned err_count  = 0;
  int unsigned cmd_count  = 0;
  int unsigned tick_count = 0;
  int unsigned checked    = 0;
  int unsigned cfg_writes = 0;

  function automatic logic [ssc_pkg::SegW-1:0] hex_glyph(input logic [3:0] v);
    return HexGlyphs[v*ssc_pkg::SegW +: ssc_pkg::SegW];
  endfunction

  function automatic void fill_buf(input logic [ssc_pkg::SegW-1:0] v);
    for (int i = 0; i < Digits; i++) seg_buf[i] = v;
  endfunction

  function automatic void model_command(input ssc_pkg::in_t c);
    logic [ssc_pkg::SegW-1:0] pat;
    logic [ssc_pkg::NumW-1:0] n;
    ssc_pkg::out_t            r;
    bit                       is_last;
    case (c.op)
      ssc_pkg::OpScan: begin
        pat = seg_buf[scan_pos];
        for (int b = 0; b < 8; b++) begin
          is_last        = (b == 7);
          r.serial_bit   = pat[7-b];
          r.segments     = is_last ? pat : ssc_pkg::NoSegments;
          r.digit_select = is_last ? ~(8'b1 << scan_pos) : ssc_pkg::AllOff;
          r.last         = is_last;
          shift_exp_q.push_back(r);
        end
        scan_pos = (scan_pos + 1) % Digits;
        tick_count++;
      end
      ssc_pkg::OpSet: begin
        if (c.position < Digits)
          seg_buf[c.position[2:0]] = (c.digit_value <= 8'd15) ?
                                     hex_glyph(c.digit_value[3:0]) : c.digit_value;
      end
      ssc_pkg::OpClear: fill_buf(blank_pat);
      ssc_pkg::OpTest:  fill_buf(test_pat);
      ssc_pkg::OpShow: begin
        fill_buf(blank_pat);
        n = c.number;
        if (n == '0) begin
          seg_buf[Digits-1] = hex_glyph(4'd0);
        end else begin
          for (int k = 0; k < Digits && n != '0; k++) begin
            seg_buf[Digits-1-k] = hex_glyph(4'(n % 10));
            n = n / 10;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(input logic [ssc_pkg::CfgIdxW-1:0] idx,
                                    input logic [ssc_pkg::SegW-1:0] d);
    case (idx)
      ssc_pkg::CfgBlank: blank_pat = d;
      ssc_pkg::CfgTest:  test_pat  = d;
      default: ;
    endcase
  endfunction

  function automatic int unsigned wait_draw(input bit paced);
    return paced ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic ssc_pkg::in_t rand_cmd();
    ssc_pkg::in_t c;
    int unsigned  w;
    c.op          = ssc_pkg::OpScan;
    c.position    = 4'($urandom_range(0, 15));
    c.digit_value = 8'($urandom_range(0, 255));
    c.number      = $urandom;
    w = $urandom_range(0, 99);
    if (w < 45) begin
      c.op = ssc_pkg::OpScan;
    end else if (w < 70) begin
      c.op = ssc_pkg::OpSet;
      if ($urandom_range(0, 4) != 0) c.position[3] = 1'b0;
      if ($urandom_range(0, 1) != 0) c.digit_value[7:4] = 4'd0;
    end else if (w < 85) begin
      c.op = ssc_pkg::OpShow;
      c.number = c.number >> $urandom_range(0, 31);
      if ($urandom_range(0, 9) == 0) c.number = '0;
    end else if (w < 90) begin
      c.op = ssc_pkg::OpClear;
    end else if (w < 95) begin
      c.op = ssc_pkg::OpTest;
    end else begin
      case ($urandom_range(0, 2))
        0:       c.op = OpRsv5;
        1:       c.op = OpRsv6;
        default: c.op = OpRsv7;
      endcase
    end
    return c;
  endfunction

  function automatic void push_cmd(input logic [ssc_pkg::OpW-1:0] op,
                                   input logic [ssc_pkg::PosW-1:0] pos,
                                   input logic [ssc_pkg::SegW-1:0] val,
                                   input logic [ssc_pkg::NumW-1:0] num);
    ssc_pkg::in_t c;
    c.op          = op;
    c.position    = pos;
    c.digit_value = val;
    c.number      = num;
    cmd_q.push_back(c);
  endfunction

  task automatic write_reg(input logic [ssc_pkg::CfgIdxW-1:0] idx,
                           input logic [ssc_pkg::SegW-1:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid_i || shift_exp_q.size() != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (cmd_q.size() > 0) begin
        in_i       <= cmd_q.pop_front();
        in_valid_i <= 1'b1;
        in_gap     <= wait_draw(in_pace);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    int unsigned hold;
    hold = out_taken ? wait_draw(out_pace) : out_hold;
    if (hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold    <= hold - 1;
    end else begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end
  end

  // transaction monitor
  always @(posedge clk_i) begin
    ssc_pkg::out_t want;
    in_taken  <= rst_ni && in_valid_i && !in_stall_o;
    out_taken <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      model_command(in_i);
      cmd_count++;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shift_exp_q.size() == 0) begin
        $error("unexpected shift transaction %p", out_o);
        err_count++;
      end else begin
        want = shift_exp_q.pop_front();
        checked++;
        if (out_o.serial_bit !== want.serial_bit) begin
          $error("serial_bit: expected %b, got %b", want.serial_bit, out_o.serial_bit);
          err_count++;
        end
        if (out_o.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, out_o.segments);
          err_count++;
        end
        if (out_o.digit_select !== want.digit_select) begin
          $error("digit_select: expected %h, got %h", want.digit_select, out_o.digit_select);
          err_count++;
        end
        if (out_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_o.last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

  initial begin
    fill_buf(ssc_pkg::BlankReset);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: edge positions and values, ignored positions, zero and overlong numbers
    push_cmd(ssc_pkg::OpSet, 4'd0, 8'd0, '0);
    push_cmd(ssc_pkg::OpSet, 4'd7, 8'd15, '0);
    push_cmd(ssc_pkg::OpSet, 4'd3, 8'd16, '0);
    push_cmd(ssc_pkg::OpSet, 4'd5, 8'd255, '0);
    push_cmd(ssc_pkg::OpSet, 4'd8, 8'd1, '0);
    push_cmd(ssc_pkg::OpSet, 4'd15, 8'd0, '1);
    repeat (8) push_cmd(ssc_pkg::OpScan, '0, '0, '0);
    push_cmd(ssc_pkg::OpShow, '0, '0, 32'd0);
    push_cmd(ssc_pkg::OpScan, '1, '1, '1);
    push_cmd(ssc_pkg::OpShow, '0, '0, 32'hFFFF_FFFF);
    push_cmd(ssc_pkg::OpScan, '0, '0, '0);
    push_cmd(ssc_pkg::OpClear, '1, '1, '1);
    push_cmd(ssc_pkg::OpScan, '0, '0, '0);
    push_cmd(ssc_pkg::OpTest, '0, '0, '0);
    push_cmd(ssc_pkg::OpScan, '0, '0, '0);
    push_cmd(OpRsv5, 4'd2, 8'd3, 32'd4);
    push_cmd(OpRsv6, 4'd0, 8'd0, '0);
    push_cmd(OpRsv7, '1, '1, '1);
    wait_idle();

    for (int p = 1; p <= NumPhases; p++) begin
      in_pace  = (p % 3) != 0;
      out_pace = (p % 2) == 0;
      case (p)
        1: begin
          write_reg(ssc_pkg::CfgBlank, 8'h00);
          write_reg(ssc_pkg::CfgTest, 8'hFF);
        end
        2: begin
          write_reg(CfgRsv2, 8'($urandom));
          write_reg(CfgRsv3, 8'($urandom));
          write_reg(ssc_pkg::CfgBlank, 8'($urandom));
          write_reg(ssc_pkg::CfgTest, 8'($urandom));
        end
        3: begin
          write_reg(ssc_pkg::CfgBlank, 8'hFF);
          write_reg(ssc_pkg::CfgTest, 8'hFF);
        end
        4: begin
          write_reg(ssc_pkg::CfgBlank, 8'h00);
          write_reg(ssc_pkg::CfgTest, 8'h00);
        end
        default: begin
          write_reg(ssc_pkg::CfgBlank, 8'($urandom));
          write_reg(ssc_pkg::CfgTest, 8'($urandom));
        end
      endcase
      repeat (RandPerPhase) cmd_q.push_back(rand_cmd());
      wait_idle();
    end

    $display("Sent %0d commands (%0d scan ticks) over %0d pattern settings,",
             cmd_count, tick_count, NumPhases + 1);
    $display("%0d register writes; compared %0d shift transactions, %0d mismatches.",
             cfg_writes, checked, err_count);
    if (err_count == 0 && shift_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
